// File: rtl/wwsm_pkg.sv
// Package for the wide-word stack machine ALU: payload types, operation codes, constants.
`timescale 1ns / 1ps
package wwsm_pkg;

  localparam int LIMB_W = 64;
  localparam int LIMBS  = 4;
  localparam int FUNC_W = 5;

  localparam logic [FUNC_W-1:0] FN_ADD        = 5'd0;
  localparam logic [FUNC_W-1:0] FN_SUB        = 5'd1;
  localparam logic [FUNC_W-1:0] FN_MUL        = 5'd2;
  localparam logic [FUNC_W-1:0] FN_DIV        = 5'd3;
  localparam logic [FUNC_W-1:0] FN_SDIV       = 5'd4;
  localparam logic [FUNC_W-1:0] FN_MOD        = 5'd5;
  localparam logic [FUNC_W-1:0] FN_SMOD       = 5'd6;
  localparam logic [FUNC_W-1:0] FN_ADDMOD     = 5'd7;
  localparam logic [FUNC_W-1:0] FN_MULMOD     = 5'd8;
  localparam logic [FUNC_W-1:0] FN_EXP        = 5'd9;
  localparam logic [FUNC_W-1:0] FN_NOT        = 5'd10;
  localparam logic [FUNC_W-1:0] FN_LT         = 5'd11;
  localparam logic [FUNC_W-1:0] FN_GT         = 5'd12;
  localparam logic [FUNC_W-1:0] FN_SLT        = 5'd13;
  localparam logic [FUNC_W-1:0] FN_SGT        = 5'd14;
  localparam logic [FUNC_W-1:0] FN_EQ         = 5'd15;
  localparam logic [FUNC_W-1:0] FN_ISZERO     = 5'd16;
  localparam logic [FUNC_W-1:0] FN_AND        = 5'd17;
  localparam logic [FUNC_W-1:0] FN_OR         = 5'd18;
  localparam logic [FUNC_W-1:0] FN_XOR        = 5'd19;
  localparam logic [FUNC_W-1:0] FN_BYTE       = 5'd20;
  localparam logic [FUNC_W-1:0] FN_SIGNEXTEND = 5'd21;

  // Byte and signextend index limits.
  localparam int BYTE_COUNT   = 32;
  localparam int SIGNEXT_MAX  = 30;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [LIMB_W-1:0] operand_a_limb;
    logic [LIMB_W-1:0] operand_b_limb;
    logic [LIMB_W-1:0] operand_c_limb;
    logic              last_limb;
  } in_t;

  typedef struct packed {
    logic [LIMB_W-1:0] result_limb;
    logic              result_last;
  } out_t;

  typedef struct packed {
    logic start;
    logic modular;
  } mul_ctl_t;

endpackage

// File: rtl/wwsm_div.sv
// Bit-serial restoring divider: (W+1)-bit numerator by W-bit divisor, one quotient bit per cycle.
`timescale 1ns / 1ps
module wwsm_div #(
  parameter int W = wwsm_pkg::LIMBS * wwsm_pkg::LIMB_W
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W:0]   num,
  input  logic [W-1:0] den,
  output logic         done,
  output logic [W-1:0] quo,
  output logic [W-1:0] rem
);
  import wwsm_pkg::*;

  localparam int CW = $clog2(W + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [W:0]    n;
  logic [W-1:0]  r;
  logic [W-1:0]  d;
  logic [W:0]    rs;
  logic [W+1:0]  diff;
  logic          fits;

  assign rs   = {r, n[W]};
  assign diff = {1'b0, rs} - {2'b00, d};
  assign fits = !diff[W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(W);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // The quotient bits shift in behind the numerator bits as they leave.
  always_ff @(posedge clk) begin
    if (start) begin
      n <= num;
      r <= '0;
      d <= den;
    end else if (busy) begin
      n <= {n[W-1:0], fits};
      r <= fits ? diff[W-1:0] : rs[W-1:0];
    end
  end

  assign quo = n[W-1:0];
  assign rem = r;

endmodule

// File: rtl/wwsm_mul.sv
// Bit-serial multiplier, MSB first, a doubling phase and an add phase per bit; plain mode wraps, modular mode reduces.
`timescale 1ns / 1ps
module wwsm_mul #(
  parameter int W = wwsm_pkg::LIMBS * wwsm_pkg::LIMB_W
) (
  input  logic                clk,
  input  logic                rst,
  input  wwsm_pkg::mul_ctl_t  ctl,
  input  logic [W-1:0]        x,
  input  logic [W-1:0]        y,
  input  logic [W-1:0]        m,
  output logic                done,
  output logic [W-1:0]        prod
);
  import wwsm_pkg::*;

  localparam int CW = $clog2(W);

  logic          busy;
  logic          phase;
  logic          modular;
  logic [CW-1:0] cnt;
  logic [W-1:0]  xs;
  logic [W-1:0]  ys;
  logic [W-1:0]  ms;
  logic [W-1:0]  r;
  logic [W:0]    sum;
  logic [W+1:0]  red;

  // In modular mode the multiplicand is below the modulus, so one subtract keeps r reduced.
  always_comb begin
    if (!phase) begin
      sum = {r, 1'b0};
    end else begin
      sum = {1'b0, r} + {1'b0, (xs[W-1] ? ys : '0)};
    end
    red = {1'b0, sum} - {2'b00, ms};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      phase <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy  <= 1'b1;
        phase <= 1'b0;
        cnt   <= CW'(W - 1);
      end else if (busy) begin
        phase <= !phase;
        if (phase) begin
          if (cnt == '0) begin
            busy <= 1'b0;
            done <= 1'b1;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      xs      <= x;
      ys      <= y;
      ms      <= m;
      modular <= ctl.modular;
      r       <= '0;
    end else if (busy) begin
      r <= (modular && !red[W+1]) ? red[W-1:0] : sum[W-1:0];
      if (phase) begin
        xs <= {xs[W-2:0], 1'b0};
      end
    end
  end

  assign prod = r;

endmodule

// File: rtl/wide_word_stack_machine_alu.sv
// Top level of the wide-word stack machine ALU: limb loader, sequencer and result streamer.
`timescale 1ns / 1ps
// Operands arrive as limb transfers, least significant first; the operation code is taken
// from the first limb, and the limb flagged last (or the fourth) starts the operation. No
// limb is taken while an operation runs or its four result limbs are being streamed out.
// Logic, compare, add, sub, byte and signextend results are registered at dispatch.
// div, mod, sdiv, smod and addmod run the bit-serial divider unless the divisor is zero
// (or all ones, for sdiv and smod). mul runs the bit-serial multiplier. mulmod first
// reduces b with the divider, then multiplies modulo c. exp squares for every bit of
// the exponent and multiplies for every one bit. The shift-add units are shared by
// these operations. Results go out in four transfers, one per cycle when the sink is
// ready.
module wide_word_stack_machine_alu #(
  parameter int LIMBS = wwsm_pkg::LIMBS
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  wwsm_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output wwsm_pkg::out_t out_data
);
  import wwsm_pkg::*;

  localparam int W  = LIMBS * LIMB_W;
  localparam int IW = $clog2(LIMBS);
  localparam int EW = $clog2(W);

  typedef enum logic [4:0] {
    ST_LOAD = 5'b00001,
    ST_EXEC = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_MUL  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  state_t            state;
  logic [IW-1:0]     limb_cnt;
  logic [IW-1:0]     out_cnt;
  logic [FUNC_W-1:0] func;
  logic [W-1:0]      a;
  logic [W-1:0]      b;
  logic [W-1:0]      c;
  logic [W-1:0]      res;
  logic [EW-1:0]     exp_idx;
  logic              sq;
  logic              go;

  logic              in_xfer;
  logic              out_xfer;
  logic              load_done;
  logic [W-1:0]      a_next;
  logic [W-1:0]      b_next;
  logic [W-1:0]      c_next;

  logic              a_neg;
  logic              b_neg;
  logic [W-1:0]      a_abs;
  logic [W-1:0]      b_abs;
  logic              b_zero;
  logic              b_ones;
  logic              c_zero;
  logic [W-1:0]      simple_res;
  logic [4:0]        byte_sel;
  logic [7:0]        sx_pos;
  logic [W-1:0]      sx_keep;

  logic              div_start;
  logic [W:0]        div_num;
  logic [W-1:0]      div_den;
  logic              div_done;
  logic [W-1:0]      div_quo;
  logic [W-1:0]      div_rem;

  mul_ctl_t          mul_ctl;
  logic [W-1:0]      mul_x;
  logic [W-1:0]      mul_y;
  logic              mul_done;
  logic [W-1:0]      mul_prod;

  assign in_ready  = (state == ST_LOAD);
  assign out_valid = (state == ST_OUT);
  assign in_xfer   = in_valid && in_ready;
  assign out_xfer  = out_valid && out_ready;
  assign load_done = in_data.last_limb || (limb_cnt == IW'(LIMBS - 1));

  assign out_data.result_limb = res[out_cnt * LIMB_W +: LIMB_W];
  assign out_data.result_last = (out_cnt == IW'(LIMBS - 1));

  // The first limb of an operation clears the rest, so limbs never sent read as zero.
  always_comb begin
    a_next = (limb_cnt == '0) ? '0 : a;
    b_next = (limb_cnt == '0) ? '0 : b;
    c_next = (limb_cnt == '0) ? '0 : c;
    a_next[limb_cnt * LIMB_W +: LIMB_W] = in_data.operand_a_limb;
    b_next[limb_cnt * LIMB_W +: LIMB_W] = in_data.operand_b_limb;
    c_next[limb_cnt * LIMB_W +: LIMB_W] = in_data.operand_c_limb;
  end

  assign a_neg  = a[W-1];
  assign b_neg  = b[W-1];
  assign a_abs  = a_neg ? ('0 - a) : a;
  assign b_abs  = b_neg ? ('0 - b) : b;
  assign b_zero = (b == '0);
  assign b_ones = (b == '1);
  assign c_zero = (c == '0);

  assign byte_sel = 5'(BYTE_COUNT - 1) - a[4:0];
  assign sx_pos   = {a[4:0], 3'b111};
  assign sx_keep  = (W'(2) << sx_pos) - W'(1);

  always_comb begin
    simple_res = '0;
    case (func)
      FN_ADD:    simple_res = a + b;
      FN_SUB:    simple_res = a - b;
      FN_NOT:    simple_res = ~a;
      FN_LT:     simple_res = W'(a < b);
      FN_GT:     simple_res = W'(a > b);
      FN_SLT:    simple_res = W'($signed(a) < $signed(b));
      FN_SGT:    simple_res = W'($signed(a) > $signed(b));
      FN_EQ:     simple_res = W'(a == b);
      FN_ISZERO: simple_res = W'(a == '0);
      FN_AND:    simple_res = a & b;
      FN_OR:     simple_res = a | b;
      FN_XOR:    simple_res = a ^ b;
      FN_BYTE: begin
        if (a[W-1:5] == '0) begin
          simple_res = W'(b[{byte_sel, 3'b000} +: 8]);
        end
      end
      FN_SIGNEXTEND: begin
        simple_res = b;
        if (a[W-1:5] == '0 && a[4:0] <= 5'(SIGNEXT_MAX)) begin
          simple_res = b[sx_pos] ? (b | ~sx_keep) : (b & sx_keep);
        end
      end
      default:   simple_res = '0;
    endcase
  end

  // Divider operands; the signed forms divide magnitudes.
  always_comb begin
    div_start = go && (state == ST_DIV);
    div_num   = {1'b0, a};
    div_den   = b;
    case (func)
      FN_SDIV, FN_SMOD: begin
        div_num = {1'b0, a_abs};
        div_den = b_abs;
      end
      FN_ADDMOD: begin
        div_num = {1'b0, a} + {1'b0, b};
        div_den = c;
      end
      FN_MULMOD: begin
        div_num = {1'b0, b};
        div_den = c;
      end
      default: begin
        div_num = {1'b0, a};
        div_den = b;
      end
    endcase
  end

  assign mul_ctl.start   = go && (state == ST_MUL);
  assign mul_ctl.modular = (func == FN_MULMOD);
  assign mul_x = (func == FN_EXP && sq) ? res : a;
  assign mul_y = (func == FN_MUL) ? b : res;

  wwsm_div #(.W(W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  wwsm_mul #(.W(W)) u_mul (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mul_ctl),
    .x    (mul_x),
    .y    (mul_y),
    .m    (c),
    .done (mul_done),
    .prod (mul_prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      limb_cnt <= '0;
      out_cnt  <= '0;
      func     <= FN_ADD;
      go       <= 1'b0;
    end else begin
      go <= 1'b0;
      case (state)
        ST_LOAD: begin
          if (in_xfer) begin
            if (limb_cnt == '0) begin
              func <= in_data.func;
            end
            if (load_done) begin
              limb_cnt <= '0;
              state    <= ST_EXEC;
            end else begin
              limb_cnt <= limb_cnt + 1'b1;
            end
          end
        end
        ST_EXEC: begin
          case (func)
            FN_DIV, FN_MOD: begin
              state <= b_zero ? ST_OUT : ST_DIV;
              go    <= !b_zero;
            end
            FN_SDIV: begin
              state <= (b_zero || b_ones) ? ST_OUT : ST_DIV;
              go    <= !(b_zero || b_ones);
            end
            FN_SMOD: begin
              state <= (b_zero || b_ones) ? ST_OUT : ST_DIV;
              go    <= !(b_zero || b_ones);
            end
            FN_ADDMOD, FN_MULMOD: begin
              state <= c_zero ? ST_OUT : ST_DIV;
              go    <= !c_zero;
            end
            FN_MUL, FN_EXP: begin
              state <= ST_MUL;
              go    <= 1'b1;
            end
            default: state <= ST_OUT;
          endcase
        end
        ST_DIV: begin
          if (div_done) begin
            if (func == FN_MULMOD) begin
              state <= ST_MUL;
              go    <= 1'b1;
            end else begin
              state <= ST_OUT;
            end
          end
        end
        ST_MUL: begin
          if (mul_done) begin
            if (func != FN_EXP) begin
              state <= ST_OUT;
            end else if (sq && b[exp_idx]) begin
              go <= 1'b1;
            end else if (exp_idx == '0) begin
              state <= ST_OUT;
            end else begin
              go <= 1'b1;
            end
          end
        end
        ST_OUT: begin
          if (out_xfer) begin
            out_cnt <= out_cnt + 1'b1;
            if (out_cnt == IW'(LIMBS - 1)) begin
              state <= ST_LOAD;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  // Operand and result registers; the sequencer above decides when they move.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      a <= a_next;
      b <= b_next;
      c <= c_next;
    end
    case (state)
      ST_EXEC: begin
        case (func)
          FN_DIV, FN_MOD, FN_SMOD, FN_ADDMOD, FN_MULMOD: res <= '0;
          FN_SDIV: res <= b_ones ? ('0 - a) : '0;
          FN_MUL:  res <= '0;
          FN_EXP: begin
            res     <= W'(1);
            exp_idx <= EW'(W - 1);
            sq      <= 1'b1;
          end
          default: res <= simple_res;
        endcase
      end
      ST_DIV: begin
        if (div_done) begin
          case (func)
            FN_DIV:  res <= div_quo;
            FN_SDIV: res <= (a_neg ^ b_neg) ? ('0 - div_quo) : div_quo;
            FN_SMOD: res <= a_neg ? ('0 - div_rem) : div_rem;
            default: res <= div_rem;
          endcase
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          res <= mul_prod;
          if (func == FN_EXP) begin
            if (sq && b[exp_idx]) begin
              sq <= 1'b0;
            end else begin
              sq      <= 1'b1;
              exp_idx <= exp_idx - 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input and output sides open at once");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider finished outside its wait state");

  a_mul_done_state: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == ST_MUL))
    else $error("multiplier finished outside its wait state");

  a_last_returns: assert property (@(posedge clk) disable iff (rst)
    (out_xfer && out_data.result_last) |=> (in_ready && limb_cnt == '0))
    else $error("last result transfer did not reopen the input");

  a_exec_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC) |=> (state != ST_EXEC))
    else $error("dispatch state held longer than one cycle");

endmodule
